### hw/rtl/gne_pkg.sv
// types, constants and helper functions shared by the grid neighbour expander
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package gne_pkg;

	localparam int unsigned IdBits   = 16;
	localparam int unsigned DimBits  = 9;
	localparam int unsigned CostBits = 15;
	localparam int unsigned AreaBits = 2 * DimBits;

	localparam logic [1:0] CFG_MAP_WIDTH     = 2'd0;
	localparam logic [1:0] CFG_MAP_HEIGHT    = 2'd1;
	localparam logic [1:0] CFG_NEIGHBOR_MODE = 2'd2;

	localparam logic [1:0] MODE_FOUR   = 2'd0;
	localparam logic [1:0] MODE_RASTER = 2'd1;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_EXPAND = 1'b1;

	typedef struct packed {
		logic              func;
		logic [IdBits-1:0] cell_id;
		logic              passable;
	} req_t;

	typedef struct packed {
		logic [IdBits-1:0]   neighbor_id;
		logic [CostBits-1:0] step_cost;
		logic                found;
		logic                out_of_range;
		logic                last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CHECK,
		ST_DIV,
		ST_SCAN
	} state_t;

	typedef enum logic [2:0] {
		PUSH_NONE,
		PUSH_OOR,
		PUSH_EMPTY,
		PUSH_MID,
		PUSH_LAST
	} push_t;

	typedef struct packed {
		logic  wr;
		logic  capture;
		logic  rd_start;
		logic  div_init;
		logic  div_step;
		logic  scan_clear;
		logic  scan_adv;
		push_t push;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic oor;
		logic start_open;
		logic div_last;
		logic scan_done;
		logic need_push;
		logic pend_valid;
	} ctrl_stat_t;

	// one neighbour offset: minus or plus one in x and y, and diagonal cost
	typedef struct packed {
		logic xm;
		logic xp;
		logic ym;
		logic yp;
		logic diag;
	} nbr_t;

	function automatic nbr_t nbr_offset(input logic [1:0] mode, input logic [2:0] k);
		nbr_t n;
		n = '0;
		if (mode == MODE_RASTER) begin
			case (k)
				3'd0: begin n.xm = 1'b1; n.ym = 1'b1; end
				3'd1: begin n.ym = 1'b1; end
				3'd2: begin n.xp = 1'b1; n.ym = 1'b1; end
				3'd3: begin n.xm = 1'b1; end
				3'd4: begin n.xp = 1'b1; end
				3'd5: begin n.xm = 1'b1; n.yp = 1'b1; end
				3'd6: begin n.yp = 1'b1; end
				default: begin n.xp = 1'b1; n.yp = 1'b1; end
			endcase
		end else begin
			case (k)
				3'd0: begin n.xm = 1'b1; end
				3'd1: begin n.xp = 1'b1; end
				3'd2: begin n.ym = 1'b1; end
				3'd3: begin n.yp = 1'b1; end
				3'd4: begin n.xm = 1'b1; n.ym = 1'b1; n.diag = 1'b1; end
				3'd5: begin n.xm = 1'b1; n.yp = 1'b1; n.diag = 1'b1; end
				3'd6: begin n.xp = 1'b1; n.ym = 1'b1; n.diag = 1'b1; end
				default: begin n.xp = 1'b1; n.yp = 1'b1; n.diag = 1'b1; end
			endcase
		end
		return n;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] val;
		logic [63:0] res;
		logic [63:0] bitv;
		val  = v;
		res  = '0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (val >= res + bitv) begin
				val = val - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [CostBits-1:0] cost_one(input int frac);
		logic [63:0] c;
		c = 64'd1 << frac;
		return c[CostBits-1:0];
	endfunction

	// sqrt2 rounded to nearest from floor(2 * sqrt2 * 2^frac)
	function automatic logic [CostBits-1:0] cost_diag(input int frac);
		logic [63:0] twice;
		logic [63:0] c;
		twice = isqrt64(64'd1 << (2 * frac + 3));
		c     = (twice + 64'd1) >> 1;
		return c[CostBits-1:0];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/gne_ctrl.sv
// sequencer of the grid neighbour expander: write, range check, divide, scan
// depends on gne_pkg
`timescale 1ns / 1ps
`default_nettype none

module gne_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	input  wire                 req_func,
	output logic                req_ready,
	input  gne_pkg::ctrl_stat_t stat,
	output gne_pkg::ctrl_cmd_t  cmd
);

	gne_pkg::state_t state_q;
	gne_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gne_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gne_pkg::ST_IDLE: begin
				if (req_valid && req_func == gne_pkg::FUNC_EXPAND) begin
					state_d = gne_pkg::ST_PREP;
				end
			end
			gne_pkg::ST_PREP: begin
				state_d = gne_pkg::ST_CHECK;
			end
			gne_pkg::ST_CHECK: begin
				if (stat.oor || !stat.start_open) begin
					if (stat.out_free) begin
						state_d = gne_pkg::ST_IDLE;
					end
				end else begin
					state_d = gne_pkg::ST_DIV;
				end
			end
			gne_pkg::ST_DIV: begin
				if (stat.div_last) begin
					state_d = gne_pkg::ST_SCAN;
				end
			end
			gne_pkg::ST_SCAN: begin
				if (stat.scan_done && stat.out_free) begin
					state_d = gne_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gne_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.push  = gne_pkg::PUSH_NONE;
		req_ready = 1'b0;
		case (state_q)
			gne_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.wr      = (req_func == gne_pkg::FUNC_WRITE);
					cmd.capture = (req_func == gne_pkg::FUNC_EXPAND);
				end
			end
			gne_pkg::ST_PREP: begin
				cmd.rd_start = 1'b1;
			end
			gne_pkg::ST_CHECK: begin
				if (stat.oor) begin
					if (stat.out_free) begin
						cmd.push = gne_pkg::PUSH_OOR;
					end
				end else if (!stat.start_open) begin
					if (stat.out_free) begin
						cmd.push = gne_pkg::PUSH_EMPTY;
					end
				end else begin
					cmd.div_init   = 1'b1;
					cmd.scan_clear = 1'b1;
				end
			end
			gne_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			gne_pkg::ST_SCAN: begin
				if (stat.scan_done) begin
					if (stat.out_free) begin
						cmd.push = stat.pend_valid ? gne_pkg::PUSH_LAST : gne_pkg::PUSH_EMPTY;
					end
				end else if (!stat.need_push || stat.out_free) begin
					cmd.scan_adv = 1'b1;
					cmd.push     = stat.need_push ? gne_pkg::PUSH_MID : gne_pkg::PUSH_NONE;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/gne_datapath.sv
// datapath of the grid neighbour expander: config registers, passable map,
// radix-4 divider, neighbour scan and result register; depends on gne_pkg
`timescale 1ns / 1ps
`default_nettype none

module gne_datapath #(
	parameter int unsigned MAX_WIDTH      = 256,
	parameter int unsigned MAX_HEIGHT     = 256,
	parameter int unsigned COST_FRAC_BITS = 14
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  gne_pkg::req_t       req,
	input  wire                 cfg_valid,
	input  wire [1:0]           cfg_index,
	input  wire [8:0]           cfg_data,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output gne_pkg::rsp_t       rsp,
	input  gne_pkg::ctrl_cmd_t  cmd,
	output gne_pkg::ctrl_stat_t stat
);

	localparam int unsigned IdW   = gne_pkg::IdBits;
	localparam int unsigned DimW  = gne_pkg::DimBits;
	localparam int unsigned AreaW = gne_pkg::AreaBits;
	localparam logic [gne_pkg::CostBits-1:0] CostOne  = gne_pkg::cost_one(COST_FRAC_BITS);
	localparam logic [gne_pkg::CostBits-1:0] CostDiag = gne_pkg::cost_diag(COST_FRAC_BITS);
	localparam logic [10:0] WidthLim  = 11'(MAX_WIDTH);
	localparam logic [10:0] HeightLim = 11'(MAX_HEIGHT);

	logic [DimW-1:0] width_q;
	logic [DimW-1:0] height_q;
	logic [1:0]      mode_q;

	logic [DimW-1:0] w_sat;
	logic [DimW-1:0] h_sat;

	logic [IdW-1:0]   id_q;
	logic [AreaW-1:0] area_q;

	logic             mem_q [0:(1 << IdW) - 1];
	logic             rdata_q;

	logic [DimW-1:0]  rem_q;
	logic [IdW-1:0]   quo_q;
	logic [2:0]       div_cnt_q;
	logic [DimW:0]    r1;
	logic [DimW-1:0]  rem1;
	logic             q1;
	logic [DimW:0]    r2;
	logic [DimW-1:0]  rem2;
	logic             q2;

	logic [3:0]       k_q;
	logic [3:0]       count;
	gne_pkg::nbr_t    cand;
	logic             inb;
	logic [AreaW-1:0] row_off;
	logic [AreaW-1:0] col_off;
	logic [AreaW-1:0] nid;
	logic             issue;
	logic             hit;

	logic             s1_valid_q;
	logic [IdW-1:0]   nid_s1;
	logic             diag_s1;
	logic             pend_valid_q;
	logic [IdW-1:0]   pend_id_q;
	logic             pend_diag_q;

	logic             out_valid_q;
	gne_pkg::rsp_t    out_q;
	gne_pkg::rsp_t    out_d;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			mode_q   <= 2'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				gne_pkg::CFG_MAP_WIDTH:     width_q  <= cfg_data;
				gne_pkg::CFG_MAP_HEIGHT:    height_q <= cfg_data;
				gne_pkg::CFG_NEIGHBOR_MODE: mode_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_sat = 9'd1;
		end else if ({2'b00, width_q} > WidthLim) begin
			w_sat = WidthLim[DimW-1:0];
		end else begin
			w_sat = width_q;
		end
		if (height_q == '0) begin
			h_sat = 9'd1;
		end else if ({2'b00, height_q} > HeightLim) begin
			h_sat = HeightLim[DimW-1:0];
		end else begin
			h_sat = height_q;
		end
	end

	// request capture and map area
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q <= req.cell_id;
		end
		if (cmd.rd_start) begin
			area_q <= w_sat * h_sat;
		end
	end

	// passable map, one write or one registered read a cycle
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[req.cell_id] <= req.passable;
		end
		if (cmd.rd_start) begin
			rdata_q <= mem_q[id_q];
		end else if (cmd.scan_adv && issue) begin
			rdata_q <= mem_q[nid[IdW-1:0]];
		end
	end

	// two quotient bits a cycle: y = id / w, x = id % w
	always_comb begin
		r1 = {rem_q, quo_q[IdW-1]};
		q1 = (r1 >= {1'b0, w_sat});
		rem1 = q1 ? DimW'(r1 - {1'b0, w_sat}) : r1[DimW-1:0];
		r2 = {rem1, quo_q[IdW-2]};
		q2 = (r2 >= {1'b0, w_sat});
		rem2 = q2 ? DimW'(r2 - {1'b0, w_sat}) : r2[DimW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_init) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= id_q;
		end else if (cmd.div_step) begin
			rem_q <= rem2;
			quo_q <= {quo_q[IdW-3:0], q1, q2};
		end
	end

	// neighbour candidate for the current scan slot
	always_comb begin
		count   = (mode_q == gne_pkg::MODE_FOUR) ? 4'd4 : 4'd8;
		cand    = gne_pkg::nbr_offset(mode_q, k_q[2:0]);
		inb     = (k_q < count)
		       && !(cand.xm && rem_q == '0)
		       && !(cand.xp && rem_q == w_sat - 9'd1)
		       && !(cand.ym && quo_q == '0)
		       && !(cand.yp && quo_q == {7'd0, h_sat - 9'd1});
		row_off = cand.yp ? {9'd0, w_sat} : (cand.ym ? AreaW'(~{9'd0, w_sat} + 18'd1) : '0);
		col_off = cand.xp ? 18'd1 : (cand.xm ? '1 : '0);
		nid     = AreaW'({2'b00, id_q} + row_off + col_off);
		issue   = inb && (nid[AreaW-1:IdW] == '0);
		hit     = s1_valid_q && rdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q          <= '0;
			s1_valid_q   <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (cmd.scan_clear) begin
			k_q          <= '0;
			s1_valid_q   <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (cmd.scan_adv) begin
			if (k_q < count) begin
				k_q <= k_q + 4'd1;
			end
			s1_valid_q <= issue;
			if (hit) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_adv) begin
			nid_s1  <= nid[IdW-1:0];
			diag_s1 <= cand.diag;
			if (hit) begin
				pend_id_q   <= nid_s1;
				pend_diag_q <= diag_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push != gne_pkg::PUSH_NONE) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		out_d = out_q;
		case (cmd.push)
			gne_pkg::PUSH_OOR: begin
				out_d              = '0;
				out_d.out_of_range = 1'b1;
				out_d.last         = 1'b1;
			end
			gne_pkg::PUSH_EMPTY: begin
				out_d      = '0;
				out_d.last = 1'b1;
			end
			gne_pkg::PUSH_MID, gne_pkg::PUSH_LAST: begin
				out_d.neighbor_id  = pend_id_q;
				out_d.step_cost    = pend_diag_q ? CostDiag : CostOne;
				out_d.found        = 1'b1;
				out_d.out_of_range = 1'b0;
				out_d.last         = (cmd.push == gne_pkg::PUSH_LAST);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		out_q <= out_d;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign stat.out_free   = !out_valid_q || rsp_ready;
	assign stat.oor        = ({2'b00, id_q} >= area_q);
	assign stat.start_open = rdata_q;
	assign stat.div_last   = (div_cnt_q == 3'd7);
	assign stat.scan_done  = (k_q == count) && !s1_valid_q;
	assign stat.need_push  = hit && pend_valid_q;
	assign stat.pend_valid = pend_valid_q;

endmodule

`default_nettype wire

### hw/rtl/grid_neighbor_expander_core.sv
// grid neighbour expander: a map write returns no beat
// an expand: prep reads the start cell and map area, then the range and start-cell check
// (the only beat for an out-of-range id or a wall), the two-bit-per-cycle divider and a
// scan through the single map read port, one neighbour slot per cycle unless a found neighbour
// waits on a busy result register; a new request is taken once the last beat is in the result register
// reset clears control and sets width 256, height 256, mode 2; map contents undefined
`timescale 1ns / 1ps
`default_nettype none

module grid_neighbor_expander_core #(
	parameter int unsigned MAX_WIDTH      = 256,
	parameter int unsigned MAX_HEIGHT     = 256,
	parameter int unsigned COST_FRAC_BITS = 14
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           req_valid,
	output logic          req_ready,
	input  gne_pkg::req_t req,
	output logic          rsp_valid,
	input  wire           rsp_ready,
	output gne_pkg::rsp_t rsp,
	input  wire           cfg_valid,
	output logic          cfg_ready,
	input  wire [1:0]     cfg_index,
	input  wire [8:0]     cfg_data
);

	gne_pkg::ctrl_cmd_t  cmd;
	gne_pkg::ctrl_stat_t stat;

	assign cfg_ready = 1'b1;

	gne_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_func  (req.func),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gne_datapath #(
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_HEIGHT     (MAX_HEIGHT),
		.COST_FRAC_BITS (COST_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for grid_neighbor_expander_core: map writes, expands and register phases
// a scoreboard class predicts the neighbour beats, plain tasks drive the request and config channels
// depends on gne_pkg and grid_neighbor_expander_core
`timescale 1ns / 1ps

class nbr_scoreboard;
	bit                  map_bits [65536];
	logic [8:0]          width_reg;
	logic [8:0]          height_reg;
	logic [1:0]          mode_reg;
	logic [14:0]         one_cost;
	logic [14:0]         diag_cost;
	gne_pkg::rsp_t       nbr_beats [$];
	int unsigned         fails;

	function new();
		int c;
		c          = $rtoi($sqrt(2.0) * 16384.0 + 0.5);
		width_reg  = 9'd256;
		height_reg = 9'd256;
		mode_reg   = 2'd2;
		one_cost   = 15'd16384;
		diag_cost  = 15'(c);
		fails      = 0;
	endfunction

	function int clamp_dim(input logic [8:0] v);
		if (v == 9'd0)
			return 1;
		if (v > 9'd256)
			return 256;
		return int'(v);
	endfunction

	function int unsigned outstanding();
		return nbr_beats.size();
	endfunction

	function void note_config(input logic [1:0] idx, input logic [8:0] data);
		if (idx == gne_pkg::CFG_MAP_WIDTH)
			width_reg = data;
		else if (idx == gne_pkg::CFG_MAP_HEIGHT)
			height_reg = data;
		else if (idx == gne_pkg::CFG_NEIGHBOR_MODE)
			mode_reg = data[1:0];
	endfunction

	function void note_request(input gne_pkg::req_t r);
		int            w, h, x, y, nx, ny, nid, n, i, first;
		int            dxs [8];
		int            dys [8];
		bit            dg [8];
		gne_pkg::rsp_t b;
		if (r.func == gne_pkg::FUNC_WRITE) begin
			map_bits[r.cell_id] = r.passable;
			return;
		end
		w      = clamp_dim(width_reg);
		h      = clamp_dim(height_reg);
		b      = '0;
		b.last = 1'b1;
		if (int'(r.cell_id) >= w * h) begin
			b.out_of_range = 1'b1;
			nbr_beats.push_back(b);
			return;
		end
		// wall start cell
		if (!map_bits[r.cell_id]) begin
			nbr_beats.push_back(b);
			return;
		end
		x = int'(r.cell_id) % w;
		y = int'(r.cell_id) / w;
		case (mode_reg)
			gne_pkg::MODE_FOUR: begin
				n   = 4;
				dxs = '{-1, 1, 0, 0, 0, 0, 0, 0};
				dys = '{0, 0, -1, 1, 0, 0, 0, 0};
				dg  = '{0, 0, 0, 0, 0, 0, 0, 0};
			end
			gne_pkg::MODE_RASTER: begin
				n   = 8;
				dxs = '{-1, 0, 1, -1, 1, -1, 0, 1};
				dys = '{-1, -1, -1, 0, 0, 1, 1, 1};
				dg  = '{0, 0, 0, 0, 0, 0, 0, 0};
			end
			default: begin
				n   = 8;
				dxs = '{-1, 1, 0, 0, -1, -1, 1, 1};
				dys = '{0, 0, -1, 1, -1, 1, -1, 1};
				dg  = '{0, 0, 0, 0, 1, 1, 1, 1};
			end
		endcase
		first = nbr_beats.size();
		for (i = 0; i < n; i++) begin
			nx = x + dxs[i];
			ny = y + dys[i];
			if (nx < 0 || ny < 0 || nx >= w || ny >= h)
				continue;
			nid = ny * w + nx;
			if (nid > 65535 || !map_bits[nid])
				continue;
			b              = '0;
			b.neighbor_id  = 16'(nid);
			b.step_cost    = dg[i] ? diag_cost : one_cost;
			b.found        = 1'b1;
			nbr_beats.push_back(b);
		end
		if (nbr_beats.size() == first) begin
			b      = '0;
			b.last = 1'b1;
			nbr_beats.push_back(b);
		end else begin
			b      = nbr_beats.pop_back();
			b.last = 1'b1;
			nbr_beats.push_back(b);
		end
	endfunction

	function void check_result(input gne_pkg::rsp_t r);
		gne_pkg::rsp_t e;
		if (nbr_beats.size() == 0) begin
			$error("unexpected beat: neighbor_id %0d found %0b last %0b",
				r.neighbor_id, r.found, r.last);
			fails++;
			return;
		end
		e = nbr_beats.pop_front();
		if (r.neighbor_id !== e.neighbor_id) begin
			$error("neighbor_id: expected %0d, got %0d", e.neighbor_id, r.neighbor_id);
			fails++;
		end
		if (r.step_cost !== e.step_cost) begin
			$error("step_cost: expected %0d, got %0d", e.step_cost, r.step_cost);
			fails++;
		end
		if (r.found !== e.found) begin
			$error("found: expected %0b, got %0b", e.found, r.found);
			fails++;
		end
		if (r.out_of_range !== e.out_of_range) begin
			$error("out_of_range: expected %0b, got %0b", e.out_of_range, r.out_of_range);
			fails++;
		end
		if (r.last !== e.last) begin
			$error("last: expected %0b, got %0b", e.last, r.last);
			fails++;
		end
	endfunction
endclass

module tb_top;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int LIMIT        = 500000;
	localparam int SETTLE       = 32;
	localparam int HOLD_CYCLES  = 300;
	localparam int NPHASE       = 10;
	localparam int PHASE_ITEMS  = 41;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	gne_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	gne_pkg::rsp_t rsp;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [1:0]    cfg_index = '0;
	logic [8:0]    cfg_data  = '0;

	nbr_scoreboard sb;
	bit            cell_known [65536];
	int            cur_w = 256;
	int            cur_h = 256;
	int            ox, oy, rw, rh;
	int            item_count = 0;
	int            calm_left [2];
	int            cycle_count = 0;

	logic [8:0] phase_w [0:NPHASE-1] = '{9'd256, 9'd1, 9'd0, 9'd7, 9'd511,
		9'd2, 9'd16, 9'd256, 9'd13, 9'd256};
	logic [8:0] phase_h [0:NPHASE-1] = '{9'd256, 9'd9, 9'd0, 9'd5, 9'd3,
		9'd300, 9'd16, 9'd256, 9'd1, 9'd256};
	logic [1:0] phase_m [0:NPHASE-1] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
		2'd2, 2'd0, 2'd1, 2'd2, 2'd2};

	grid_neighbor_expander_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("** grid_neighbor_expander_core: FAILED **");
			$finish;
		end
	end

	function automatic int pick_gap(input int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm_left[side] = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	task automatic send_req(input logic f, input int id, input logic p);
		gne_pkg::req_t r;
		int            gap;
		r.func     = f;
		r.cell_id  = id[15:0];
		r.passable = p;
		gap = pick_gap(0);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
		if (f == gne_pkg::FUNC_WRITE)
			cell_known[r.cell_id] = 1'b1;
		item_count++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.note_config(idx, data);
	endtask

	task automatic set_grid(input logic [8:0] w, input logic [8:0] h, input logic [1:0] m);
		logic [8:0] mode_word;
		mode_word = 9'($urandom_range(0, 511));
		mode_word[1:0] = m;
		drain();
		write_reg(gne_pkg::CFG_MAP_WIDTH, w);
		write_reg(gne_pkg::CFG_MAP_HEIGHT, h);
		write_reg(gne_pkg::CFG_NEIGHBOR_MODE, mode_word);
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_UNUSED, 9'($urandom_range(0, 511)));
		cfg_valid <= 1'b0;
		cur_w = sb.clamp_dim(w);
		cur_h = sb.clamp_dim(h);
	endtask

	// every cell an expand may read is written first
	task automatic expand_at(input int id);
		int x, y, nx, ny;
		if (id < cur_w * cur_h) begin
			x = id % cur_w;
			y = id / cur_w;
			for (ny = y - 1; ny <= y + 1; ny++)
				for (nx = x - 1; nx <= x + 1; nx++)
					if (nx >= 0 && ny >= 0 && nx < cur_w && ny < cur_h &&
							!cell_known[ny * cur_w + nx])
						send_req(gne_pkg::FUNC_WRITE, ny * cur_w + nx,
							$urandom_range(0, 2) != 0);
		end
		send_req(gne_pkg::FUNC_EXPAND, id, 1'($urandom_range(0, 1)));
	endtask

	function automatic int region_id();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, cur_w * cur_h - 1);
		return (oy + $urandom_range(0, rh - 1)) * cur_w + ox + $urandom_range(0, rw - 1);
	endfunction

	task automatic pick_region();
		rw = (cur_w < 5) ? cur_w : 5;
		rh = (cur_h < 5) ? cur_h : 5;
		case ($urandom_range(0, 2))
			0: begin
				ox = 0;
				oy = 0;
			end
			1: begin
				ox = cur_w - rw;
				oy = cur_h - rh;
			end
			default: begin
				ox = $urandom_range(0, cur_w - rw);
				oy = $urandom_range(0, cur_h - rh);
			end
		endcase
	endtask

	task automatic random_item();
		int sel, area;
		area = cur_w * cur_h;
		sel  = $urandom_range(0, 99);
		if (sel < 55)
			expand_at(region_id());
		else if (sel < 65)
			expand_at($urandom_range(0, area - 1));
		else if (sel < 77 && area < 65536)
			send_req(gne_pkg::FUNC_EXPAND, $urandom_range(area, 65535),
				1'($urandom_range(0, 1)));
		else if (sel < 88)
			send_req(gne_pkg::FUNC_WRITE, region_id(), 1'($urandom_range(0, 1)));
		else
			send_req(gne_pkg::FUNC_WRITE, $urandom_range(0, 65535),
				1'($urandom_range(0, 1)));
	endtask

	initial begin : rsp_side
		int gap;
		int beats;
		beats = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// long hold so the block backs up into the request channel
			if (beats == 40 || beats == 260) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = pick_gap(1);
			if (gap != 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			sb.check_result(rsp);
			beats++;
		end
	end

	initial begin : req_side
		int p;
		int phase_end;
		sb = new();
		wait (arst_n === 1'b1);
		@(posedge clk);

		// corner with open orthogonal and diagonal neighbours
		send_req(gne_pkg::FUNC_WRITE, 0, 1'b1);
		send_req(gne_pkg::FUNC_WRITE, 1, 1'b1);
		send_req(gne_pkg::FUNC_WRITE, 256, 1'b1);
		send_req(gne_pkg::FUNC_WRITE, 257, 1'b1);
		send_req(gne_pkg::FUNC_EXPAND, 0, 1'b0);
		// wall start at the far corner
		send_req(gne_pkg::FUNC_WRITE, 65535, 1'b0);
		send_req(gne_pkg::FUNC_EXPAND, 65535, 1'b1);
		// open cell boxed in by walls
		send_req(gne_pkg::FUNC_WRITE, 255, 1'b1);
		send_req(gne_pkg::FUNC_WRITE, 254, 1'b0);
		send_req(gne_pkg::FUNC_WRITE, 511, 1'b0);
		send_req(gne_pkg::FUNC_WRITE, 510, 1'b0);
		send_req(gne_pkg::FUNC_EXPAND, 255, 1'b0);
		// tiny grid and ids past its end
		set_grid(9'd3, 9'd2, 2'd2);
		expand_at(4);
		send_req(gne_pkg::FUNC_EXPAND, 6, 1'b1);
		send_req(gne_pkg::FUNC_EXPAND, 65535, 1'b0);

		for (p = 0; p < NPHASE; p++) begin
			set_grid(phase_w[p], phase_h[p], phase_m[p]);
			pick_region();
			phase_end = item_count + PHASE_ITEMS;
			while (item_count < phase_end)
				random_item();
		end

		drain();
		if (sb.fails == 0 && sb.outstanding() == 0)
			$display("** grid_neighbor_expander_core: PASSED **");
		else
			$display("** grid_neighbor_expander_core: FAILED **");
		$finish;
	end

endmodule
